FILE: hw/rtl/sbt_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and classification functions of the tokenizer.
package sbt_pkg;

	localparam int unsigned POSITION_BITS_DEF = 32;
	localparam int unsigned LENGTH_BITS_DEF   = 16;

	// Result queue between the scanner and the output channel.
	localparam int unsigned RES_DEPTH    = 4;
	localparam int unsigned RES_PTR_BITS = $clog2(RES_DEPTH);

	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_LAMBDA_0 = 8'hCE;
	localparam logic [7:0] CH_LAMBDA_1 = 8'hBB;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;

	typedef enum logic [3:0] {
		TK_LAMBDA   = 4'd0,
		TK_LPAREN   = 4'd1,
		TK_RPAREN   = 4'd2,
		TK_LBRACKET = 4'd3,
		TK_RBRACKET = 4'd4,
		TK_NUMBER   = 4'd5,
		TK_BOOLEAN  = 4'd6,
		TK_IDENT    = 4'd7,
		TK_EOF      = 4'd8,
		TK_ERROR    = 4'd9
	} token_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_NUMBER  = 3'd2,
		MODE_IDENT   = 3'd3,
		MODE_LAMBDA  = 3'd4,
		MODE_ERROR   = 3'd5
	} scan_mode_t;

	// Progress through the keywords "true" and "false".
	typedef logic [3:0] kw_state_t;
	localparam kw_state_t KW_NONE  = 4'd0;
	localparam kw_state_t KW_T     = 4'd1;
	localparam kw_state_t KW_TR    = 4'd2;
	localparam kw_state_t KW_TRU   = 4'd3;
	localparam kw_state_t KW_TRUE  = 4'd4;
	localparam kw_state_t KW_F     = 4'd5;
	localparam kw_state_t KW_FA    = 4'd6;
	localparam kw_state_t KW_FAL   = 4'd7;
	localparam kw_state_t KW_FALS  = 4'd8;
	localparam kw_state_t KW_FALSE = 4'd9;

	typedef struct packed {
		token_kind_t kind;
		logic [31:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

	// Up to two results that one item pushes into the queue, in order.
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_ident_start(input logic [7:0] b);
		return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z")) ||
			(b == "_") || (b == "+") || (b == "-") || (b == "*") || (b == "/") ||
			(b == "%") || (b == "<") || (b == ">") || (b == "=") || (b == "?") ||
			(b == "!");
	endfunction

	function automatic kw_state_t kw_next(input kw_state_t km, input logic [7:0] b);
		kw_state_t r;
		r = KW_NONE;
		unique case (km)
			KW_T:    if (b == "r") r = KW_TR;
			KW_TR:   if (b == "u") r = KW_TRU;
			KW_TRU:  if (b == "e") r = KW_TRUE;
			KW_F:    if (b == "a") r = KW_FA;
			KW_FA:   if (b == "l") r = KW_FAL;
			KW_FAL:  if (b == "s") r = KW_FALS;
			KW_FALS: if (b == "e") r = KW_FALSE;
			default: r = KW_NONE;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/sbt_in_if.sv
`timescale 1ns / 1ps
// Handshake channel that carries source bytes into the tokenizer.
interface sbt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

FILE: hw/rtl/sbt_tok_if.sv
`timescale 1ns / 1ps
// Handshake channel that carries tokens out of the tokenizer.
interface sbt_tok_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [31:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input last_of_run, output ready);
endinterface

FILE: hw/rtl/sbt_scan.sv
`timescale 1ns / 1ps
// Scanner state machine: classifies one byte per cycle while fire is set and forms up to two tokens.
module sbt_scan import sbt_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output push_t      push
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	scan_mode_t               mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [POSITION_BITS-1:0] start_q, start_d;
	logic [LENGTH_BITS-1:0]   len_q, len_d, len_inc;
	kw_state_t                kw_q, kw_d;
	logic                     flush_v, main_v, scan_byte;
	token_t                   flush_tok, main_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			kw_q    <= KW_NONE;
		end else begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
			kw_q    <= kw_d;
		end
	end

	assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + LENGTH_BITS'(1);

	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		start_d   = start_q;
		len_d     = len_q;
		kw_d      = kw_q;
		flush_v   = 1'b0;
		main_v    = 1'b0;
		scan_byte = 1'b0;

		// The open token as it would be closed now.
		flush_tok.start  = 32'(start_q);
		flush_tok.last   = 1'b0;
		flush_tok.length = 16'(len_q);
		if (mode_q == MODE_NUMBER) begin
			flush_tok.kind = TK_NUMBER;
		end else if (mode_q == MODE_IDENT) begin
			flush_tok.kind = ((kw_q == KW_TRUE) || (kw_q == KW_FALSE)) ? TK_BOOLEAN : TK_IDENT;
		end else begin
			flush_tok.kind   = TK_ERROR;
			flush_tok.length = 16'd1;
		end

		main_tok.kind   = TK_ERROR;
		main_tok.start  = 32'(pos_q);
		main_tok.length = 16'd1;
		main_tok.last   = 1'b1;

		if (fire) begin
			if (end_of_input) begin
				flush_v = (mode_q == MODE_NUMBER) || (mode_q == MODE_IDENT) ||
					(mode_q == MODE_LAMBDA);
				main_v          = 1'b1;
				main_tok.kind   = TK_EOF;
				main_tok.length = 16'd0;
				mode_d  = MODE_IDLE;
				pos_d   = '0;
				start_d = '0;
				len_d   = '0;
				kw_d    = KW_NONE;
			end else begin
				pos_d = pos_q + POSITION_BITS'(1);
				unique case (mode_q)
					MODE_COMMENT: begin
						if (data_byte == CH_LF) mode_d = MODE_IDLE;
					end
					MODE_ERROR: begin
						mode_d = MODE_ERROR;
					end
					MODE_LAMBDA: begin
						main_v         = 1'b1;
						main_tok.start = 32'(start_q);
						if (data_byte == CH_LAMBDA_1) begin
							main_tok.kind   = TK_LAMBDA;
							main_tok.length = 16'd2;
							mode_d          = MODE_IDLE;
						end else begin
							mode_d = MODE_ERROR;
						end
					end
					MODE_NUMBER: begin
						if (is_digit(data_byte)) begin
							len_d = len_inc;
						end else begin
							flush_v   = 1'b1;
							scan_byte = 1'b1;
						end
					end
					MODE_IDENT: begin
						if (is_ident_start(data_byte) || is_digit(data_byte)) begin
							len_d = len_inc;
							kw_d  = kw_next(kw_q, data_byte);
						end else begin
							flush_v   = 1'b1;
							scan_byte = 1'b1;
						end
					end
					default: begin
						scan_byte = 1'b1;
					end
				endcase

				// The byte starts something new, from the idle mode.
				if (scan_byte) begin
					mode_d = MODE_IDLE;
					if (is_space(data_byte)) begin
						mode_d = MODE_IDLE;
					end else if (data_byte == CH_HASH) begin
						mode_d = MODE_COMMENT;
					end else if (data_byte == CH_LAMBDA_0) begin
						mode_d  = MODE_LAMBDA;
						start_d = pos_q;
						len_d   = LENGTH_BITS'(1);
					end else if (data_byte == CH_LPAREN) begin
						main_v        = 1'b1;
						main_tok.kind = TK_LPAREN;
					end else if (data_byte == CH_RPAREN) begin
						main_v        = 1'b1;
						main_tok.kind = TK_RPAREN;
					end else if (data_byte == CH_LBRACKET) begin
						main_v        = 1'b1;
						main_tok.kind = TK_LBRACKET;
					end else if (data_byte == CH_RBRACKET) begin
						main_v        = 1'b1;
						main_tok.kind = TK_RBRACKET;
					end else if (is_digit(data_byte)) begin
						mode_d  = MODE_NUMBER;
						start_d = pos_q;
						len_d   = LENGTH_BITS'(1);
					end else if (is_ident_start(data_byte)) begin
						mode_d  = MODE_IDENT;
						start_d = pos_q;
						len_d   = LENGTH_BITS'(1);
						kw_d    = (data_byte == "t") ? KW_T :
							(data_byte == "f") ? KW_F : KW_NONE;
					end else begin
						main_v = 1'b1;
						mode_d = MODE_ERROR;
					end
				end
			end
		end

		push.count       = {flush_v & main_v, flush_v ^ main_v};
		push.first       = flush_v ? flush_tok : main_tok;
		push.first.last  = !(flush_v && main_v);
		push.second      = main_tok;
	end

`ifndef ASSERT_OFF
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_input |=> (mode_q == MODE_IDLE) && (pos_q == '0))
		else $error("state not cleared after end item");
	a_pair_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> (push.first.kind == TK_NUMBER) ||
			(push.first.kind == TK_BOOLEAN) || (push.first.kind == TK_IDENT) ||
			(push.first.kind == TK_ERROR))
		else $error("two results without a closed token first");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> push.count == 2'd0)
		else $error("result formed without an item");
	a_error_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !end_of_input && (mode_q == MODE_ERROR) |-> push.count == 2'd0)
		else $error("result formed while discarding input");
`endif

endmodule

FILE: hw/rtl/sbt_res_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two tokens a cycle and hands one a cycle to the output channel while it is ready.
module sbt_res_fifo import sbt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  push_t            push,
	output logic             room,
	sbt_tok_if.source        tokens
);

	token_t                  mem_q [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] wr_q, rd_q;
	logic [RES_PTR_BITS:0]   count_q;
	logic                    pop;

	// Room for a full pair, regardless of what leaves this cycle.
	assign room = count_q <= (RES_PTR_BITS+1)'(RES_DEPTH - 2);
	assign pop  = tokens.valid && tokens.ready;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_q] <= push.first;
		if (push.count == 2'd2) mem_q[wr_q + RES_PTR_BITS'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_PTR_BITS'(push.count);
			rd_q    <= rd_q + RES_PTR_BITS'(pop);
			count_q <= count_q + (RES_PTR_BITS+1)'(push.count) - (RES_PTR_BITS+1)'(pop);
		end
	end

	assign tokens.valid        = count_q != '0;
	assign tokens.token_kind   = mem_q[rd_q].kind;
	assign tokens.token_start  = mem_q[rd_q].start;
	assign tokens.token_length = mem_q[rd_q].length;
	assign tokens.last_of_run  = mem_q[rd_q].last;

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("result queue written without room");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (RES_PTR_BITS+1)'(RES_DEPTH))
		else $error("result queue count out of range");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd0) && !pop |=> $stable(count_q))
		else $error("result queue count moved without traffic");
`endif

endmodule

FILE: hw/rtl/sexpr_byte_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the S-expression byte tokenizer.
//
// source_text takes one item a cycle while ready is high: a byte, or an end item (end_of_input
// set, byte ignored). tokens delivers the results as kind, start position and
// length, with last_of_run marking the final result of the item that caused it.
// An item is taken on the edge where valid and ready are both high.
//
// An accepted item is held in the input register and scanned there; while the
// result queue has room its results are written to the queue, from which tokens
// presents them. The scanner retires one item a cycle while the queue has room,
// updating its state (mode, position, open token) for each item in turn.
// An item that closes a token and starts another gives two results, which the
// four-entry result queue absorbs.
//
// Reset clears the scanner to idle at position zero and empties the queue.
// When the receiver stalls, results collect in the queue; once it cannot take
// a further pair the scanner holds and, with an item held, source_text drops ready.
module sexpr_byte_tokenizer import sbt_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sbt_in_if.sink    source_text,
	sbt_tok_if.source tokens
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       room;
	logic       fire;
	push_t      push;

	assign fire              = valid_s1 && room;
	assign source_text.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (source_text.ready) begin
			valid_s1 <= source_text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (source_text.ready && source_text.valid) begin
			byte_s1 <= source_text.data_byte;
			end_s1  <= source_text.end_of_input;
		end
	end

	sbt_scan #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (byte_s1),
		.end_of_input(end_s1),
		.push        (push)
	);

	sbt_res_fifo u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.tokens(tokens)
	);

`ifndef ASSERT_OFF
	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		source_text.valid && source_text.ready |=> valid_s1)
		else $error("accepted item not held in the input register");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(byte_s1) && $stable(end_s1))
		else $error("stalled item lost from the input register");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |-> !source_text.ready)
		else $error("input taken while the scanner is held");
`endif

endmodule
